// ===== src/usb_pd_bmc_4b5b_frame_encoder_assert.svh =====
`ifndef USB_PD_BMC_4B5B_FRAME_ENCODER_ASSERT_SVH
`define USB_PD_BMC_4B5B_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PDENC_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pdenc assertion failed");

// next-cycle implication, checked out of reset
`define PDENC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pdenc assertion failed");

`endif

// ===== src/pdenc_pkg.sv =====
`default_nettype none

package pdenc_pkg;

  localparam int PREAMBLE_BYTES = 16;
  localparam int PRE_CNT_W      = $clog2(PREAMBLE_BYTES + 1);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  PREAMBLE_CODE = 8'b10110100;
  localparam logic [9:0]  SYM_MASK      = 10'h3ff;
  localparam logic [9:0]  SYM_TOP       = 10'h200;
  localparam logic [1:0]  HIGH_BITS     = 2'b11;
  localparam logic [31:0] CRC_POLY      = 32'hedb88320;
  localparam logic [31:0] CRC_INIT      = 32'hffffffff;

  localparam logic [3:0] SYM_W    = 4'd10;
  localparam logic [3:0] HIGH_W   = 4'd2;
  localparam logic [3:0] PAD_W    = 4'd8;
  localparam logic [4:0] ACC_ROOM = 5'd16;
  localparam logic [4:0] ACC_MAX  = 5'd25;

  typedef enum logic [2:0] {
    K_SYNC1,
    K_SYNC2,
    K_SYNC3,
    K_RST1,
    K_RST2,
    K_EOP
  } ctrl_sym_t;

  typedef enum logic [2:0] {
    ST_DATA,
    ST_PRE,
    ST_OS,
    ST_CRC,
    ST_EOP,
    ST_HIGH,
    ST_PAD,
    ST_FLUSH
  } back_state_t;

  typedef struct packed {
    logic       first_byte;
    logic       last_byte;
    logic [2:0] sop_kind;
    logic [7:0] data_byte;
  } item_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } line_beat_t;

  typedef struct packed {
    logic        first_byte;
    logic        last_byte;
    logic [2:0]  sop_kind;
    logic [7:0]  data_byte;
    logic [31:0] crc;
  } entry_t;

  localparam ctrl_sym_t ORDERED_SETS [8][4] = '{
    '{K_SYNC1, K_SYNC1, K_SYNC1, K_SYNC1},
    '{K_SYNC1, K_SYNC1, K_SYNC1, K_SYNC2},
    '{K_SYNC1, K_SYNC1, K_SYNC3, K_SYNC3},
    '{K_SYNC1, K_SYNC3, K_SYNC1, K_SYNC3},
    '{K_SYNC1, K_RST2,  K_RST2,  K_SYNC3},
    '{K_SYNC1, K_RST2,  K_SYNC3, K_SYNC2},
    '{K_RST1,  K_RST1,  K_RST1,  K_RST2},
    '{K_RST1,  K_SYNC1, K_RST1,  K_SYNC3}
  };

  // line codes for a line that was low before the symbol
  localparam logic [9:0] NIBBLE_CODES [16] = '{
    10'h2ab, 10'h34d, 10'h2d3, 10'h12d, 10'h34b, 10'h0b5, 10'h0ab, 10'h355,
    10'h2cb, 10'h135, 10'h12b, 10'h2d5, 10'h14b, 10'h2b5, 10'h153, 10'h2ad
  };

  function automatic logic [9:0] control_code(input ctrl_sym_t k);
    logic [9:0] c;
    unique case (k)
      K_SYNC1: c = 10'h2b3;
      K_SYNC2: c = 10'h2cd;
      K_SYNC3: c = 10'h32b;
      K_RST1:  c = 10'h0d5;
      K_RST2:  c = 10'h14d;
      K_EOP:   c = 10'h0ad;
      default: c = 10'h0ad;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] crc_update(input logic [31:0] crc_in,
                                             input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/pdenc_queue.sv =====
`default_nettype none

module pdenc_queue
  import pdenc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  entry_t      wr_entry,
  output logic        full,
  output entry_t      head,
  output logic        head_valid,
  input  wire logic   pop
);

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  assign full       = (fill == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/pdenc_front.sv =====
`default_nettype none

module pdenc_front
  import pdenc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   item_valid,
  output logic        item_stall,
  input  item_beat_t  item,
  output entry_t      head,
  output logic        head_valid,
  input  wire logic   pop
);

  logic [31:0] crc;
  logic [31:0] crc_base;
  logic [31:0] crc_new;
  logic        full;
  logic        push;
  logic        eff_last;
  entry_t      wr_entry;

  assign item_stall = full;
  assign push       = item_valid && !full;

  // a first beat restarts the frame, so a last flag on it is dropped
  assign eff_last = item.last_byte && !item.first_byte;
  assign crc_base = item.first_byte ? CRC_INIT : crc;
  assign crc_new  = crc_update(crc_base, item.data_byte);

  always_comb begin
    wr_entry.first_byte = item.first_byte;
    wr_entry.last_byte  = eff_last;
    wr_entry.sop_kind   = item.sop_kind;
    wr_entry.data_byte  = item.data_byte;
    wr_entry.crc        = ~crc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (push) begin
      crc <= eff_last ? CRC_INIT : crc_new;
    end
  end

  pdenc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .full       (full),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

endmodule

`default_nettype wire

// ===== src/pdenc_back.sv =====
`default_nettype none

`include "usb_pd_bmc_4b5b_frame_encoder_assert.svh"

module pdenc_back
  import pdenc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  entry_t      head,
  input  wire logic   head_valid,
  output logic        pop,
  output logic        line_valid,
  input  wire logic   line_stall,
  output line_beat_t  line
);

  back_state_t          state;
  back_state_t          state_next;
  logic [2:0]           idx;
  logic [PRE_CNT_W-1:0] pre_cnt;
  logic                 hdr_done;
  logic [31:0]          acc;
  logic [4:0]           count;
  logic                 line_high;

  logic       out_free;
  logic       acc_emit;
  logic       pre_emit;
  logic [4:0] count_ae;
  logic       room;
  logic       start_wait;
  logic       drop;
  logic       flush_end;
  logic       put;
  logic       put_pol;
  logic [9:0] put_code;
  logic [3:0] put_w;
  logic [9:0] put_val;
  logic [3:0] crc_nib;
  logic [3:0] data_nib;

  assign out_free   = !line_valid || !line_stall;
  assign acc_emit   = out_free && (count >= 5'd8) && (state != ST_PRE);
  assign count_ae   = acc_emit ? count - 5'd8 : count;
  assign room       = count_ae < ACC_ROOM;
  assign start_wait = (state == ST_DATA) && head_valid && head.first_byte && !hdr_done;
  assign crc_nib    = 4'(head.crc >> {idx, 2'b00});
  assign data_nib   = idx[0] ? head.data_byte[7:4] : head.data_byte[3:0];
  assign put_val    = put_pol ? (put_code ^ (line_high ? SYM_MASK : '0)) : put_code;

  always_comb begin
    put       = 1'b0;
    put_pol   = 1'b1;
    put_code  = '0;
    put_w     = SYM_W;
    pop       = 1'b0;
    drop      = 1'b0;
    flush_end = 1'b0;
    pre_emit  = 1'b0;
    unique case (state)
      ST_DATA: begin
        if (head_valid) begin
          if (start_wait) begin
            drop = count_ae < 5'd8;
          end else if (room) begin
            put      = 1'b1;
            put_code = NIBBLE_CODES[data_nib];
            pop      = idx[0] && !head.last_byte;
          end
        end
      end
      ST_PRE: begin
        pre_emit = out_free;
      end
      ST_OS: begin
        put      = room;
        put_code = control_code(ORDERED_SETS[head.sop_kind][idx[1:0]]);
      end
      ST_CRC: begin
        put      = room;
        put_code = NIBBLE_CODES[crc_nib];
      end
      ST_EOP: begin
        put      = room;
        put_code = control_code(K_EOP);
      end
      ST_HIGH: begin
        put      = room && !line_high;
        put_pol  = 1'b0;
        put_code = {8'd0, HIGH_BITS};
        put_w    = HIGH_W;
      end
      ST_PAD: begin
        put     = room;
        put_pol = 1'b0;
        put_w   = PAD_W;
      end
      ST_FLUSH: begin
        flush_end = acc_emit && (count_ae < 5'd8);
        pop       = flush_end;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_DATA: begin
        if (drop) begin
          state_next = ST_PRE;
        end else if (put && idx[0] && head.last_byte) begin
          state_next = ST_CRC;
        end
      end
      ST_PRE: begin
        if (pre_emit && (pre_cnt == PRE_CNT_W'(PREAMBLE_BYTES - 1))) begin
          state_next = ST_OS;
        end
      end
      ST_OS: begin
        if (put && (idx == 3'd3)) begin
          state_next = ST_DATA;
        end
      end
      ST_CRC: begin
        if (put && (idx == 3'd7)) begin
          state_next = ST_EOP;
        end
      end
      ST_EOP: begin
        if (put) begin
          state_next = ST_HIGH;
        end
      end
      ST_HIGH: begin
        if (line_high || put) begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (put) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_end) begin
          state_next = ST_DATA;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_DATA;
      idx       <= '0;
      pre_cnt   <= '0;
      hdr_done  <= 1'b0;
      acc       <= '0;
      count     <= '0;
      line_high <= 1'b1;
      line_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state || pop) begin
        idx <= '0;
      end else if (put) begin
        idx <= idx + 1'b1;
      end
      if (state != ST_PRE) begin
        pre_cnt <= '0;
      end else if (pre_emit) begin
        pre_cnt <= pre_cnt + 1'b1;
      end
      if (pop) begin
        hdr_done <= 1'b0;
      end else if (state == ST_OS && state_next == ST_DATA) begin
        hdr_done <= 1'b1;
      end
      if (drop || flush_end) begin
        acc       <= '0;
        count     <= '0;
        line_high <= 1'b1;
      end else begin
        acc   <= (acc_emit ? (acc >> 8) : acc)
               | (put ? (32'(put_val) << count_ae[3:0]) : '0);
        count <= count_ae + (put ? {1'b0, put_w} : 5'd0);
        if (put && put_pol) begin
          line_high <= (put_val & SYM_TOP) != '0;
        end
      end
      if (out_free) begin
        line_valid <= acc_emit || pre_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      line.out_byte  <= pre_emit ? PREAMBLE_CODE : acc[7:0];
      line.frame_end <= flush_end;
    end
  end

  `PDENC_ASSERT_NOW(a_count_bound, 1'b1, count <= ACC_MAX)
  `PDENC_ASSERT_NOW(a_pre_empty, state == ST_PRE, count == '0)
  `PDENC_ASSERT_NOW(a_pop_valid, pop, head_valid)
  `PDENC_ASSERT_NEXT(a_flush_reset, flush_end, (count == '0) && line_high && (state == ST_DATA))

endmodule

`default_nettype wire

// ===== src/usb_pd_bmc_4b5b_frame_encoder.sv =====
// A middle beat passes the queue, the bit accumulator and the line output register in turn.
// The byte emitter gives one line byte per cycle unless line_stall holds the output;
// the front keeps taking beats into the queue while the emitter works on earlier ones.
// A 4-entry queue between the front and the byte emitter absorbs line stalls.
// Reset: queue empty, CRC all ones, line high, bit accumulator empty; no clearing pass.
`default_nettype none

module usb_pd_bmc_4b5b_frame_encoder
  import pdenc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   item_valid,
  output logic        item_stall,
  input  item_beat_t  item,
  output logic        line_valid,
  input  wire logic   line_stall,
  output line_beat_t  line
);

  entry_t head;
  logic   head_valid;
  logic   pop;

  pdenc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  pdenc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line       (line)
  );

endmodule

`default_nettype wire
